@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, masked while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, with no reset mask.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ltc_pkg.sv @@
// Types, character constants and helper functions for the literal type classifier.
`timescale 1ns / 1ps

package ltc_pkg;

  typedef enum logic [3:0] {
    PH_START = 4'd0,
    PH_SIGN  = 4'd1,
    PH_INT   = 4'd2,
    PH_DOT   = 4'd3,
    PH_FRAC  = 4'd4,
    PH_FLT   = 4'd5,
    PH_DEAD  = 4'd6
  } scan_phase_t;

  typedef enum logic [2:0] {
    TY_UNKNOWN = 3'd0,
    TY_CHAR    = 3'd1,
    TY_INT     = 3'd2,
    TY_FLOAT   = 3'd3,
    TY_DOUBLE  = 3'd4
  } lit_type_t;

  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_F     = 8'h66;  // 'f'
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned NUM_WORDS = 3;

  // Special words: "nan", "+inf", "-inf" (bit 0, 1, 2 of the alive mask).
  localparam logic [7:0] WORD_TEXT [NUM_WORDS][4] = '{
    '{8'h6E, 8'h61, 8'h6E, 8'h00},
    '{8'h2B, 8'h69, 8'h6E, 8'h66},
    '{8'h2D, 8'h69, 8'h6E, 8'h66}
  };
  localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{3'd3, 3'd4, 3'd4};

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic special_done(input logic [2:0] alive, input logic [2:0] pos);
    return ((pos == 3'd3) && alive[0]) || ((pos == 3'd4) && (alive[1] || alive[2]));
  endfunction

  function automatic scan_phase_t next_phase(input scan_phase_t ph, input logic [7:0] c);
    scan_phase_t nx;
    nx = PH_DEAD;
    unique case (ph) inside
      PH_START: begin
        if (is_digit(c)) nx = PH_INT;
        else if ((c == CH_PLUS) || (c == CH_MINUS)) nx = PH_SIGN;
      end
      PH_SIGN: begin
        if (is_digit(c)) nx = PH_INT;
      end
      PH_INT: begin
        if (is_digit(c)) nx = PH_INT;
        else if (c == CH_DOT) nx = PH_DOT;
      end
      PH_DOT, PH_FRAC: begin
        if (is_digit(c)) nx = PH_FRAC;
      end
      default: nx = PH_DEAD;
    endcase
    return nx;
  endfunction

endpackage

@@ rtl/literal_type_classifier.sv @@
// Literal type classifier: one character per word in, one type code per literal out.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A literal arrives one character per input word, its final word flagged by
// last (has_char=0 on a last word ends it without a character; has_char=0
// on a non-last word is ignored). One result word carrying literal_type
// (0 unknown, 1 char, 2 int, 3 float, 4 double) follows each last word,
// in the cycle after it is accepted. A new input word is taken every cycle:
// the recognizer state updates in a single pass of short logic, and the
// result register is the only thing that can hold the input off, so
// item_ready drops only while a result waits and result_ready is low.
// After each literal the recognizer returns to its start state.
module literal_type_classifier (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [7:0] char_code,
  input  logic       has_char,
  input  logic       last,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [2:0] literal_type
);

  // Recognizer state
  ltc_pkg::scan_phase_t scan_phase, scan_phase_next;
  logic [1:0] char_count, char_count_next;
  logic [2:0] special_alive, special_alive_next;
  logic [2:0] special_pos, special_pos_next;
  logic       prior_double_ok, prior_double_ok_next;
  logic       first_is_digit, first_is_digit_next;

  // State after this word's character, before the end-of-literal reset
  ltc_pkg::scan_phase_t upd_phase;
  logic [1:0] upd_count;
  logic [2:0] upd_alive;
  logic [2:0] upd_pos;
  logic       upd_prior;
  logic       upd_first;

  ltc_pkg::lit_type_t lit_type;
  logic accept;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  always_comb begin
    upd_phase = scan_phase;
    upd_count = char_count;
    upd_alive = special_alive;
    upd_pos   = special_pos;
    upd_prior = prior_double_ok;
    upd_first = first_is_digit;
    if (has_char) begin
      // trailing 'f' after a complete double turns it into a float
      if ((char_code == ltc_pkg::CH_F) && prior_double_ok) begin
        upd_phase = ltc_pkg::PH_FLT;
      end else begin
        upd_phase = ltc_pkg::next_phase(scan_phase, char_code);
      end
      for (int k = 0; k < ltc_pkg::NUM_WORDS; k++) begin
        upd_alive[k] = special_alive[k] && (special_pos < ltc_pkg::WORD_LEN[k]) &&
                       (ltc_pkg::WORD_TEXT[k][special_pos[1:0]] == char_code);
      end
      upd_pos = (special_pos == 3'd7) ? special_pos : special_pos + 3'd1;
      if (char_count == 2'd0) begin
        upd_first = ltc_pkg::is_digit(char_code);
      end
      upd_count = (char_count == 2'd3) ? char_count : char_count + 2'd1;
      upd_prior = (upd_phase == ltc_pkg::PH_FRAC) ||
                  ltc_pkg::special_done(upd_alive, upd_pos);
    end
  end

  // Classification, tried in order char, int, float, double
  always_comb begin
    if (upd_count == 2'd0) begin
      lit_type = ltc_pkg::TY_UNKNOWN;
    end else if ((upd_count == 2'd1) && !upd_first) begin
      lit_type = ltc_pkg::TY_CHAR;
    end else if (upd_phase == ltc_pkg::PH_INT) begin
      lit_type = ltc_pkg::TY_INT;
    end else if (upd_phase == ltc_pkg::PH_FLT) begin
      lit_type = ltc_pkg::TY_FLOAT;
    end else if (upd_prior) begin
      lit_type = ltc_pkg::TY_DOUBLE;
    end else begin
      lit_type = ltc_pkg::TY_UNKNOWN;
    end
  end

  always_comb begin
    scan_phase_next      = scan_phase;
    char_count_next      = char_count;
    special_alive_next   = special_alive;
    special_pos_next     = special_pos;
    prior_double_ok_next = prior_double_ok;
    first_is_digit_next  = first_is_digit;
    if (accept) begin
      if (last) begin
        scan_phase_next      = ltc_pkg::PH_START;
        char_count_next      = 2'd0;
        special_alive_next   = 3'b111;
        special_pos_next     = 3'd0;
        prior_double_ok_next = 1'b0;
        first_is_digit_next  = 1'b0;
      end else begin
        scan_phase_next      = upd_phase;
        char_count_next      = upd_count;
        special_alive_next   = upd_alive;
        special_pos_next     = upd_pos;
        prior_double_ok_next = upd_prior;
        first_is_digit_next  = upd_first;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase      <= ltc_pkg::PH_START;
      char_count      <= 2'd0;
      special_alive   <= 3'b111;
      special_pos     <= 3'd0;
      prior_double_ok <= 1'b0;
      first_is_digit  <= 1'b0;
    end else begin
      scan_phase      <= scan_phase_next;
      char_count      <= char_count_next;
      special_alive   <= special_alive_next;
      special_pos     <= special_pos_next;
      prior_double_ok <= prior_double_ok_next;
      first_is_digit  <= first_is_digit_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      literal_type <= lit_type;
    end
  end

  // Checks
  `ASSERT_CLK(a_end_gives_result, (accept && last) |=> result_valid,
              "literal end did not raise a result")
  `ASSERT_CLK(a_end_resets_state,
              (accept && last) |=> (scan_phase == ltc_pkg::PH_START) &&
              (char_count == 2'd0) && (special_alive == 3'b111) && (special_pos == 3'd0),
              "recognizer not back at start after literal end")
  `ASSERT_CLK(a_empty_word_holds,
              (accept && !has_char && !last) |=> $stable(scan_phase) && $stable(char_count) &&
              $stable(special_pos),
              "word without character changed recognizer state")
  `ASSERT_CLK(a_type_range, result_valid |-> (literal_type <= ltc_pkg::TY_DOUBLE),
              "result type code out of range")

endmodule
